### hdl/fra_pkg.sv
// Shared types, codes and constants of the fan-out reply aggregator.
package fra_pkg;

  localparam int Slots      = 16;
  localparam int MaxNodes   = 32;
  localparam int MaxResults = 16;
  localparam int ResCntW    = $clog2(MaxResults + 1);

  localparam logic [15:0] WindowReset = 16'd1000;
  localparam logic [5:0]  ErrSat      = 6'd63;

  typedef enum logic [1:0] {
    CmdOpen = 2'd0,
    CmdErr  = 2'd1,
    CmdTick = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KindOpenOk  = 2'd0,
    KindOpenRej = 2'd1,
    KindFinal   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] stream_id;
    logic [5:0]  sent_count;
    logic [31:0] error_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] out_stream_id;
    logic [5:0]  error_count;
    logic [5:0]  expected_count;
    logic [31:0] verdict_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] stream;
    logic [5:0]  expected;
    logic [5:0]  errors;
    logic [31:0] first_err;
    logic [15:0] countdown;
  } slot_t;

  // sequencer -> update unit
  typedef struct packed {
    cmd_e     cmd;
    logic     busy;
    logic     res_full;
    in_item_t item;
  } scan_ctx_t;

  // update unit -> sequencer
  typedef struct packed {
    logic      hit;
    logic      set_busy;
    logic      clr_busy;
    logic      wr_en;
    slot_t     wr_entry;
    logic      res_valid;
    out_item_t res;
  } slot_eval_t;

endpackage

### hdl/fra_stream_if.sv
// Valid/ready stream interface used for the input, result and config channels.
interface fra_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/fra_slot_mem.sv
// Slot table storage: one write port, one registered read port.
module fra_slot_mem import fra_pkg::*; #(
  parameter int SLOTS = Slots
) (
  input  logic                                      clk_i,
  input  logic                                      wr_en_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr_i,
  input  slot_t                                     wr_data_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr_i,
  output slot_t                                     rd_data_o
);

  slot_t mem_q [SLOTS];
  slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/fra_slot_eval.sv
// Shared slot update unit: evaluates one slot against the current command.
module fra_slot_eval import fra_pkg::*; (
  input  scan_ctx_t   ctx_i,
  input  slot_t       entry_i,
  input  logic [15:0] window_i,
  output slot_eval_t  ev_o
);

  logic [5:0]  errs_n;
  logic [31:0] first_n;
  logic        match;
  logic        expired;

  assign errs_n  = (entry_i.errors == ErrSat) ? entry_i.errors : entry_i.errors + 6'd1;
  assign first_n = (entry_i.first_err != 32'd0) ? entry_i.first_err :
                   (ctx_i.item.error_code != 32'd0) ? ctx_i.item.error_code : 32'd1;
  assign match   = ctx_i.busy && (entry_i.stream == ctx_i.item.stream_id);
  assign expired = entry_i.countdown <= 16'd1;

  always_comb begin
    ev_o          = '0;
    ev_o.wr_entry = entry_i;
    unique case (ctx_i.cmd)
      CmdOpen: begin
        if (!ctx_i.busy) begin
          ev_o.hit                = 1'b1;
          ev_o.set_busy           = 1'b1;
          ev_o.wr_en              = 1'b1;
          ev_o.wr_entry.stream    = ctx_i.item.stream_id;
          ev_o.wr_entry.expected  = ctx_i.item.sent_count;
          ev_o.wr_entry.errors    = 6'd0;
          ev_o.wr_entry.first_err = 32'd0;
          ev_o.wr_entry.countdown = window_i;
          ev_o.res_valid          = 1'b1;
          ev_o.res.kind           = KindOpenOk;
          ev_o.res.out_stream_id  = ctx_i.item.stream_id;
          ev_o.res.expected_count = ctx_i.item.sent_count;
        end
      end
      CmdErr: begin
        if (match) begin
          ev_o.hit = 1'b1;
          if (errs_n >= entry_i.expected) begin
            ev_o.clr_busy           = 1'b1;
            ev_o.res_valid          = 1'b1;
            ev_o.res.kind           = KindFinal;
            ev_o.res.out_stream_id  = entry_i.stream;
            ev_o.res.error_count    = errs_n;
            ev_o.res.expected_count = entry_i.expected;
            ev_o.res.verdict_code   = first_n;
          end else begin
            ev_o.wr_en              = 1'b1;
            ev_o.wr_entry.errors    = errs_n;
            ev_o.wr_entry.first_err = first_n;
          end
        end
      end
      CmdTick: begin
        if (ctx_i.busy) begin
          if (expired && !ctx_i.res_full) begin
            ev_o.clr_busy           = 1'b1;
            ev_o.res_valid          = 1'b1;
            ev_o.res.kind           = KindFinal;
            ev_o.res.out_stream_id  = entry_i.stream;
            ev_o.res.error_count    = entry_i.errors;
            ev_o.res.expected_count = entry_i.expected;
            ev_o.res.verdict_code   = entry_i.first_err;
          end else if (expired) begin
            // result rows used up: retire on the next tick
            ev_o.wr_en              = 1'b1;
            ev_o.wr_entry.countdown = 16'd0;
          end else begin
            ev_o.wr_en              = 1'b1;
            ev_o.wr_entry.countdown = entry_i.countdown - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/fra_seq.sv
// Scan sequencer: busy bits, slot walk, result holding and output register.
module fra_seq import fra_pkg::*; #(
  parameter int SLOTS = Slots
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  in_item_t                                  in_item_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output out_item_t                                 out_item_o,
  input  slot_eval_t                                ev_i,
  output scan_ctx_t                                 ctx_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr_o,
  output logic                                      wr_en_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr_o,
  output slot_t                                     wr_entry_o
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  state_e               state_q, state_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [ResCntW-1:0]   cnt_q, cnt_d;
  logic [SLOTS-1:0]     busy_q, busy_d;
  in_item_t             item_q, item_d;
  logic                 pend_valid_q, pend_valid_d;
  out_item_t            pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  cmd_e      in_cmd, cmd_q;
  logic      accept, known_cmd, sent_bad, last_slot, open_miss;
  logic      scan_res_valid, out_free, stall, step;
  out_item_t scan_res, reject_res;

  assign in_cmd    = cmd_e'(in_item_i.command);
  assign cmd_q     = cmd_e'(item_q.command);
  assign accept    = in_valid_i && (state_q == StIdle);
  assign known_cmd = (in_cmd == CmdOpen) || (in_cmd == CmdErr) || (in_cmd == CmdTick);
  assign sent_bad  = (in_item_i.sent_count == 6'd0) ||
                     (in_item_i.sent_count > 6'(MaxNodes));
  assign last_slot = idx_q == LastIdx;
  assign open_miss = (state_q == StScan) && (cmd_q == CmdOpen) && last_slot && !ev_i.hit;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    reject_res                = '0;
    reject_res.kind           = KindOpenRej;
    reject_res.out_stream_id  = (state_q == StIdle) ? in_item_i.stream_id : item_q.stream_id;
    reject_res.expected_count = (state_q == StIdle) ? in_item_i.sent_count : item_q.sent_count;
  end

  assign scan_res_valid = (state_q == StScan) && (ev_i.res_valid || open_miss);
  assign scan_res       = open_miss ? reject_res : ev_i.res;
  assign stall          = scan_res_valid && pend_valid_q && !out_free;
  assign step           = (state_q == StScan) && !stall;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if ((in_cmd == CmdOpen) && sent_bad) begin
            state_d = StDone;
          end else if (known_cmd) begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (step && (ev_i.hit || last_slot)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!pend_valid_q || out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d        = '0;
    cnt_d        = cnt_q;
    busy_d       = busy_q;
    item_d       = item_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          item_d = in_item_i;
          cnt_d  = '0;
          if ((in_cmd == CmdOpen) && sent_bad) begin
            pend_valid_d = 1'b1;
            pend_d       = reject_res;
          end
        end
      end
      StScan: begin
        if (stall) begin
          idx_d = idx_q;
        end else begin
          if (!(ev_i.hit || last_slot)) begin
            idx_d = idx_q + IdxW'(1);
          end
          if (ev_i.set_busy) begin
            busy_d[idx_q] = 1'b1;
          end
          if (ev_i.clr_busy) begin
            busy_d[idx_q] = 1'b0;
          end
          if (ev_i.res_valid && (cmd_q == CmdTick)) begin
            cnt_d = cnt_q + ResCntW'(1);
          end
          if (scan_res_valid) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            pend_valid_d = 1'b1;
            pend_d       = scan_res;
          end
        end
      end
      StDone: begin
        if (pend_valid_q && out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase

    in_ready_o     = state_q == StIdle;
    out_valid_o    = out_valid_q;
    out_item_o     = out_q;
    rd_addr_o      = idx_d;
    wr_en_o        = step && ev_i.wr_en;
    wr_addr_o      = idx_q;
    wr_entry_o     = ev_i.wr_entry;
    ctx_o.cmd      = cmd_q;
    ctx_o.busy     = busy_q[idx_q];
    ctx_o.res_full = cnt_q >= ResCntW'(MaxResults);
    ctx_o.item     = item_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= '0;
      cnt_q        <= '0;
      busy_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (idx_q <= LastIdx))
    else $error("scan index past last slot");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_valid_q)
    else $error("held result left behind at idle");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StScan) && (cmd_q != CmdTick) && scan_res_valid) |-> !pend_valid_q)
    else $error("open or reply produced more than one result");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(MaxResults))
    else $error("tick result count overflow");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> ((state_q == StScan) && (idx_q == $past(idx_q)) && pend_valid_q))
    else $error("scan moved during result stall");

endmodule

### hdl/fanout_reply_aggregator.sv
// Fan-out reply aggregator: outstanding-request completion table, top level.
// Throughput: one command at a time. An open walks the slots up to the lowest
//   free one, a reply up to its match, a tick all SLOTS; the slot walk goes
//   through the one shared update unit, one slot per cycle unless a result stall holds it.
// The last result goes from the held register to the output register in the done state.
// Reset clears all busy bits at once; slot entries stay unset until an open writes them.
module fanout_reply_aggregator import fra_pkg::*; #(
  parameter int SLOTS = Slots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fra_stream_if.sink   in_if,
  fra_stream_if.source out_if,
  fra_stream_if.sink   cfg_if
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // deadline window register, loaded into a slot's countdown at open
  logic [15:0] window_q;

  slot_eval_t      ev;
  scan_ctx_t       ctx;
  slot_t           rd_entry, wr_entry;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic            wr_en;
  in_item_t        in_item;
  out_item_t       out_item;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_if.valid && cfg_if.ready) begin
      window_q <= 16'(cfg_if.data);
    end
  end

  assign in_item     = in_if.data;
  assign out_if.data = out_item;

  // sequencer: walks slots, owns busy bits, holds back each result in a register
  // so the last flag is known before it leaves
  fra_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_item_i   (in_item),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_item_o  (out_item),
    .ev_i        (ev),
    .ctx_o       (ctx),
    .rd_addr_o   (rd_addr),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_entry_o  (wr_entry)
  );

  // shared update unit: stream compare, error fold, countdown
  fra_slot_eval u_eval (
    .ctx_i    (ctx),
    .entry_i  (rd_entry),
    .window_i (window_q),
    .ev_o     (ev)
  );

  fra_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

endmodule

### verif/tb_fanout_reply_aggregator.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fan-out reply aggregator completion table.
module tb_fanout_reply_aggregator import fra_pkg::*; ();

  // Command code 3 has no meaning in the block; it must be dropped silently.
  localparam logic [1:0] CmdUnknown   = 2'd3;
  // Idle time after the last result before the block is taken as quiet:
  // a tick walks every slot, one per cycle unless a result stall holds it, plus margin.
  localparam int         SettleCycles = 2 * Slots + 8;
  localparam int         PoolSize     = 12;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fra_stream_if #(.payload_t(in_item_t))    in_if ();
  fra_stream_if #(.payload_t(out_item_t))   out_if ();
  fra_stream_if #(.payload_t(logic [15:0])) cfg_if ();

  fanout_reply_aggregator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the slot table and the window register.
  // ---------------------------------------------------------------------------
  logic        slot_busy [Slots];
  logic [31:0] slot_stream [Slots];
  logic [5:0]  slot_expected [Slots];
  logic [5:0]  slot_errors [Slots];
  logic [31:0] slot_first_err [Slots];
  logic [15:0] slot_countdown [Slots];
  logic [15:0] window_ticks = WindowReset;

  out_item_t   pending_results[$];   // results still owed by the block, oldest first
  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          opens_ok       = 0;
  int          opens_rejected = 0;
  int          fanouts_closed = 0;
  int          full_ticks     = 0;   // ticks that closed a whole table at once
  bit          idle_on        = 1'b0;
  int          stall_left     = 0;
  logic [31:0] id_pool [PoolSize];

  // Finalize row for a slot; also frees it.
  function automatic out_item_t close_slot(int s);
    out_item_t r;
    r                = '0;
    r.kind           = KindFinal;
    r.out_stream_id  = slot_stream[s];
    r.error_count    = slot_errors[s];
    r.expected_count = slot_expected[s];
    r.verdict_code   = slot_first_err[s];
    slot_busy[s]     = 1'b0;
    return r;
  endfunction

  // Apply one accepted command to the shadow table and queue what it must produce.
  function automatic void apply_to_table(in_item_t it);
    out_item_t rows[$];
    out_item_t r;
    int        hit;
    hit = -1;
    case (it.command)
      CmdOpen: begin
        // lowest free slot wins
        for (int s = 0; s < Slots; s++) begin
          if (!slot_busy[s]) begin
            hit = s;
            break;
          end
        end
        r                = '0;
        r.out_stream_id  = it.stream_id;
        r.expected_count = it.sent_count;
        if (it.sent_count == 0 || it.sent_count > MaxNodes || hit < 0) begin
          r.kind = KindOpenRej;
        end else begin
          r.kind              = KindOpenOk;
          slot_busy[hit]      = 1'b1;
          slot_stream[hit]    = it.stream_id;
          slot_expected[hit]  = it.sent_count;
          slot_errors[hit]    = '0;
          slot_first_err[hit] = '0;
          slot_countdown[hit] = window_ticks;
        end
        rows.push_back(r);
      end
      CmdErr: begin
        // duplicates: the lowest busy slot with this id takes the reply
        for (int s = 0; s < Slots; s++) begin
          if (slot_busy[s] && slot_stream[s] == it.stream_id) begin
            hit = s;
            break;
          end
        end
        if (hit >= 0) begin
          if (slot_errors[hit] < ErrSat) slot_errors[hit]++;
          if (slot_first_err[hit] == 0) begin
            slot_first_err[hit] = (it.error_code != 0) ? it.error_code : 32'd1;
          end
          if (slot_errors[hit] >= slot_expected[hit]) rows.push_back(close_slot(hit));
        end
      end
      CmdTick: begin
        for (int s = 0; s < Slots; s++) begin
          if (slot_busy[s]) begin
            if (slot_countdown[s] <= 1) begin
              // expiries past the row limit wait for the next tick
              if (rows.size() < MaxResults) rows.push_back(close_slot(s));
              else slot_countdown[s] = '0;
            end else begin
              slot_countdown[s]--;
            end
          end
        end
        if (rows.size() == Slots) full_ticks++;
      end
      default: ;
    endcase
    if (rows.size() > 0) rows[rows.size() - 1].last = 1'b1;
    foreach (rows[i]) pending_results.push_back(rows[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on ready, field-by-field check per beat.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_if.ready = 1'b0;
      stall_left   = $urandom_range(0, 4);
    end else begin
      out_if.ready = 1'b1;
    end
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with none expected, kind", 32'(got.kind), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind) flag_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.out_stream_id != want.out_stream_id) begin
          flag_mismatch("out_stream_id", got.out_stream_id, want.out_stream_id);
        end
        if (got.error_count != want.error_count) begin
          flag_mismatch("error_count", 32'(got.error_count), 32'(want.error_count));
        end
        if (got.expected_count != want.expected_count) begin
          flag_mismatch("expected_count", 32'(got.expected_count),
                        32'(want.expected_count));
        end
        if (got.verdict_code != want.verdict_code) begin
          flag_mismatch("verdict_code", got.verdict_code, want.verdict_code);
        end
        if (got.last != want.last) flag_mismatch("last", 32'(got.last), 32'(want.last));
        case (want.kind)
          KindOpenOk:  opens_ok++;
          KindOpenRej: opens_rejected++;
          default:     fanouts_closed++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side. All tasks start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // One command beat, with an optional idle burst ahead of it.
  task automatic send_cmd(logic [1:0] cmd, logic [31:0] sid, logic [5:0] sent,
                          logic [31:0] code);
    in_item_t it;
    it.command    = cmd;
    it.stream_id  = sid;
    it.sent_count = sent;
    it.error_code = code;
    if (idle_on && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 5)) @(negedge clk_i);
    in_if.data  = it;
    in_if.valid = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    apply_to_table(it);
    items_sent++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // Hold off until every owed result is in and the block has finished its walk.
  task automatic wait_results_settled();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Window register write, only with the block quiet.
  task automatic set_window(logic [15:0] ticks);
    wait_results_settled();
    cfg_if.data  = ticks;
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    window_ticks = ticks;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Empty the table: tick when deadlines are near, else feed replies to the
  // lowest busy slot until it completes.
  task automatic clear_table();
    int far_ticks;
    int low_slot;
    forever begin
      far_ticks = 0;
      low_slot  = -1;
      for (int s = Slots - 1; s >= 0; s--) begin
        if (slot_busy[s]) begin
          low_slot = s;
          if (int'(slot_countdown[s]) > far_ticks) far_ticks = int'(slot_countdown[s]);
        end
      end
      if (low_slot < 0) break;
      if (far_ticks <= 24) send_cmd(CmdTick, $urandom, 6'($urandom), $urandom);
      else send_cmd(CmdErr, slot_stream[low_slot], 6'($urandom), $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset window, an error reply short of completion, a quiet tick, zero code.
  task automatic test_reset_window();
    send_cmd(CmdOpen, id_pool[2], 6'd2, $urandom);
    send_cmd(CmdErr, id_pool[2], 6'($urandom), 32'd0);     // stored as 1, no result
    send_cmd(CmdTick, $urandom, 6'($urandom), $urandom);   // 999 ticks left
    send_cmd(CmdErr, id_pool[2], 6'($urandom), $urandom);  // completes, verdict 1
  endtask

  // Zero and out-of-range forward counts.
  task automatic test_open_rejects();
    send_cmd(CmdOpen, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF);
    send_cmd(CmdOpen, 32'hFFFF_FFFF, 6'd33, 32'h0000_0000);
    send_cmd(CmdOpen, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
  endtask

  // Unknown command and a reply that matches nothing: both leave no trace.
  task automatic test_ignored_items();
    send_cmd(CmdUnknown, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF);
    send_cmd(CmdErr, id_pool[4], 6'h3F, 32'hFFFF_FFFF);
  endtask

  // Window of zero acts as one tick; a duplicate id is served lowest slot first.
  task automatic test_zero_window_duplicates();
    set_window(16'd0);
    send_cmd(CmdOpen, id_pool[3], 6'd1, $urandom);
    send_cmd(CmdOpen, id_pool[3], 6'd1, $urandom);
    send_cmd(CmdErr, id_pool[3], 6'($urandom), 32'hFFFF_FFFF);
    send_cmd(CmdTick, $urandom, 6'($urandom), $urandom);
  endtask

  // Full table rejects, then one tick closes every slot at the row limit.
  task automatic test_table_full();
    set_window(16'd1);
    for (int s = 0; s < Slots; s++) send_cmd(CmdOpen, $urandom, 6'(MaxNodes), $urandom);
    send_cmd(CmdOpen, id_pool[5], 6'd5, $urandom);
    send_cmd(CmdTick, $urandom, 6'($urandom), $urandom);
  endtask

  // Random traffic, mostly well-formed: opens on a small id pool, replies aimed
  // at busy slots, ticks; some out-of-range counts and stray commands.
  task automatic test_random_phase(logic [15:0] ticks, int n_items, bit with_idle);
    int          busy_list[$];
    int          pick;
    int          done;
    logic [31:0] sid;
    logic [5:0]  sent;
    logic [31:0] code;
    set_window(ticks);
    idle_on = with_idle;
    done    = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      sid  = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, PoolSize - 1)];
      code = $urandom;
      if (pick < 30) begin
        case ($urandom_range(0, 9))
          0:       sent = 6'($urandom_range(0, 63));
          1, 2:    sent = 6'($urandom_range(1, MaxNodes));
          default: sent = 6'($urandom_range(1, 4));
        endcase
        send_cmd(CmdOpen, sid, sent, code);
      end else if (pick < 65) begin
        busy_list.delete();
        for (int s = 0; s < Slots; s++) if (slot_busy[s]) busy_list.push_back(s);
        if (busy_list.size() > 0 && $urandom_range(0, 4) != 0) begin
          sid = slot_stream[busy_list[$urandom_range(0, busy_list.size() - 1)]];
        end
        if ($urandom_range(0, 3) == 0) code = '0;
        send_cmd(CmdErr, sid, 6'($urandom), code);
      end else if (pick < 95) begin
        send_cmd(CmdTick, $urandom, 6'($urandom), $urandom);
      end else begin
        send_cmd(CmdUnknown, $urandom, 6'($urandom), $urandom);
        done--;
      end
      done++;
      // sender holds back until the table has answered everything
      if (done == n_items / 2) wait_results_settled();
    end
    clear_table();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    for (int s = 0; s < Slots; s++) slot_busy[s] = 1'b0;
    for (int i = 0; i < PoolSize; i++) id_pool[i] = $urandom;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_window();
    test_open_rejects();
    test_ignored_items();
    test_zero_window_duplicates();
    test_table_full();

    test_random_phase(16'hFFFF, 60, 1'b1);
    test_random_phase(16'd2, 100, 1'b1);
    test_random_phase(16'($urandom_range(3, 12)), 100, 1'b1);
    test_random_phase(16'($urandom_range(1, 6)), 110, 1'b0);

    wait_results_settled();
    $display("Run covered %0d commands: %0d opens accepted, %0d rejected, %0d fan-outs closed,",
             items_sent, opens_ok, opens_rejected, fanouts_closed);
    $display("%0d full-table expiry ticks, windows 0, 1, reset value and 65535.", full_ticks);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #1_000_000;
    $display("Timeout with %0d results still owed", pending_results.size());
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
hdl/fra_pkg.sv
hdl/fra_stream_if.sv
hdl/fra_slot_mem.sv
hdl/fra_slot_eval.sv
hdl/fra_seq.sv
hdl/fanout_reply_aggregator.sv
verif/tb_fanout_reply_aggregator.sv
